@@ src/btd256_pkg.sv @@
package btd256_pkg;

	localparam int VALUE_BITS_DEF = 256;
	localparam int MAX_DIGITS_DEF = 78;
	localparam int DIGITS_PER_RESULT_DEF = 4;

	localparam int IN_DATA_W = 256;
	localparam int DIGIT_W = 4;
	localparam int GROUP_W = 16;
	localparam int COUNT_W = 3;
	localparam int OUT_DATA_W = 24;

	localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} cmd_t;

endpackage

@@ src/btd256_datapath.sv @@
module btd256_datapath
	import btd256_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                 clk,
	input  cmd_t                 cmd,
	input  logic [IN_DATA_W-1:0] value,
	output logic [DIGIT_W-1:0]   top_digit
);

	localparam int BCD_W = MAX_DIGITS * DIGIT_W;

	logic [VALUE_BITS-1:0] value_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;

	// add-3 correction on every digit, all in parallel
	always_comb begin
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] >= BCD_ADJ_LIMIT) begin
				bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
			end else begin
				bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value[VALUE_BITS-1:0];
			bcd_q   <= '0;
		end else if (cmd.step) begin
			value_q <= {value_q[VALUE_BITS-2:0], 1'b0};
			bcd_q   <= {bcd_adj[BCD_W-2:0], value_q[VALUE_BITS-1]};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];

endmodule

@@ src/btd256_ctrl.sv @@
module btd256_ctrl
	import btd256_pkg::*;
#(
	parameter int VALUE_BITS        = VALUE_BITS_DEF,
	parameter int MAX_DIGITS        = MAX_DIGITS_DEF,
	parameter int DIGITS_PER_RESULT = DIGITS_PER_RESULT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	input  logic [DIGIT_W-1:0]    top_digit,
	output cmd_t                  cmd
);

	localparam int BIT_W = $clog2(VALUE_BITS);
	localparam int REM_W = $clog2(MAX_DIGITS + 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DABBLE  = 3'd1;
	localparam logic [2:0] ST_SCAN    = 3'd2;
	localparam logic [2:0] ST_COLLECT = 3'd3;
	localparam logic [2:0] ST_PUSH    = 3'd4;

	logic [2:0]         state_q;
	logic [BIT_W-1:0]   bit_cnt_q;
	logic [REM_W-1:0]   rem_q;
	logic [COUNT_W-1:0] n_q;
	logic [GROUP_W-1:0] group_q;
	logic               m_tvalid_q;
	logic [GROUP_W-1:0] out_group_q;
	logic [COUNT_W-1:0] out_n_q;
	logic               out_last_q;
	logic               accept;
	logic               skip_zero;
	logic               push_ok;
	logic [COUNT_W-1:0] n_next;
	logic [GROUP_W-1:0] digit_placed;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign skip_zero = (rem_q > REM_W'(1)) && (top_digit == '0);
	assign push_ok   = !m_tvalid_q || m_tready;
	assign n_next    = n_q + COUNT_W'(1);
	assign digit_placed = {top_digit, {(GROUP_W-DIGIT_W){1'b0}}} >> {n_q, 2'b00};

	always_comb begin
		cmd.load  = accept;
		cmd.step  = (state_q == ST_DABBLE);
		cmd.shift = ((state_q == ST_SCAN) && skip_zero) || (state_q == ST_COLLECT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			rem_q      <= '0;
			n_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_PUSH) && push_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_cnt_q <= BIT_W'(VALUE_BITS - 1);
						state_q   <= ST_DABBLE;
					end
				end
				ST_DABBLE: begin
					bit_cnt_q <= bit_cnt_q - BIT_W'(1);
					if (bit_cnt_q == '0) begin
						rem_q   <= REM_W'(MAX_DIGITS);
						n_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (skip_zero) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= ST_COLLECT;
					end
				end
				ST_COLLECT: begin
					rem_q <= rem_q - REM_W'(1);
					n_q   <= n_next;
					if ((n_next == COUNT_W'(DIGITS_PER_RESULT)) || (rem_q == REM_W'(1))) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						n_q        <= '0;
						state_q    <= (rem_q == '0) ? ST_IDLE : ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// group assembly and output register, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			group_q <= '0;
		end else if (state_q == ST_COLLECT) begin
			group_q <= group_q | digit_placed;
		end else if ((state_q == ST_PUSH) && push_ok) begin
			out_group_q <= group_q;
			out_n_q     <= n_q;
			out_last_q  <= (rem_q == '0);
			group_q     <= '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-GROUP_W-COUNT_W){1'b0}}, out_n_q, out_group_q};
	assign m_tlast  = out_last_q;

endmodule

@@ src/binary_to_decimal_256_core.sv @@
// Converts an unsigned binary value of VALUE_BITS bits (received as four 64-bit words in
// s_tdata) to decimal and streams the digits most significant first, up to DIGITS_PER_RESULT
// BCD digits per output transfer with the earliest digit in the top nibble; leading zeros
// are dropped, zero gives the single digit 0, and tlast marks the final group. A conversion
// runs one double-dabble step per cycle on a shared add-3/shift digit register, then skips
// leading zero digits one per cycle, always keeping the last digit, then shifts out one
// digit per cycle into each group and waits in a push state after each group until the
// output register is free, so a stall on the output side holds the conversion. s_tready is
// high only between conversions; the last output group may still be waiting while the next
// value is taken.
module binary_to_decimal_256_core
	import btd256_pkg::*;
#(
	parameter int VALUE_BITS        = VALUE_BITS_DEF,
	parameter int MAX_DIGITS        = MAX_DIGITS_DEF,
	parameter int DIGITS_PER_RESULT = DIGITS_PER_RESULT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // value_w0, value_w1, value_w2, value_w3
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // digit_group, digits_valid
	output logic                  m_tlast   // last_group
);

	cmd_t               cmd;
	logic [DIGIT_W-1:0] top_digit;

	btd256_datapath #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.value     (s_tdata),
		.top_digit (top_digit)
	);

	btd256_ctrl #(
		.VALUE_BITS        (VALUE_BITS),
		.MAX_DIGITS        (MAX_DIGITS),
		.DIGITS_PER_RESULT (DIGITS_PER_RESULT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.top_digit (top_digit),
		.cmd       (cmd)
	);

endmodule
